// ----- sv/trd_pkg.sv -----
// Typed request dispatcher: shared types, codes and constants.
// No dependencies.
`default_nettype none
package trd_pkg;
   localparam int KindW   = 3;
   localparam int ClientW = 10;
   localparam int EntryW  = ClientW + KindW;
   localparam int BusyW   = 6;
   localparam int HeavyCost = 4;

   typedef enum logic [1:0] {
      EV_DISPATCH = 2'd0,
      EV_QUEUED   = 2'd1,
      EV_DONE     = 2'd2,
      EV_DROP     = 2'd3
   } event_type;

   localparam logic [KindW-1:0] K_WISDOM  = 3'd0;
   localparam logic [KindW-1:0] K_PROJECT = 3'd1;
   localparam logic [KindW-1:0] K_TELLNOW = 3'd2;
   localparam logic [KindW-1:0] K_COUNT   = 3'd3;
   localparam logic [KindW-1:0] K_COMPARE = 3'd4;

   localparam logic [1:0] CSR_WORKERS  = 2'd0;
   localparam logic [1:0] CSR_LIMIT    = 2'd1;
   localparam logic [1:0] CSR_RESERVED = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load_req;     // latch input item
      logic lookup;       // completion: read tag table
      logic free;         // completion: release contexts
      logic scan_start;   // begin worker scan of current entry
      logic scan_step;    // test one worker
      logic commit;       // place/queue/drop current entry
      logic pop_sel_pq;   // which queue to pop
      logic pop;          // load next queued entry
      logic out_done;     // present completion row, load priority pass count
      logic load_nq_pass; // load normal pass count
      logic set_last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_done;
      logic bad_kind;
      logic scan_end;     // scan finished (hit or exhausted)
      logic pass_empty;   // retry pass counter exhausted
      logic pq_empty;
      logic nq_empty;
   } sts_type;
endpackage
`default_nettype wire

// ----- sv/trd_datapath.sv -----
// Typed request dispatcher datapath: worker counts, tag table, queues, result row.
// Depends on trd_pkg.
`default_nettype none
module trd_datapath
   import trd_pkg::*;
#(
   parameter int WORKERS     = 8,
   parameter int TAG_SLOTS   = 256,
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output sts_type                 sts,
   input  wire logic               csr_valid,
   input  wire logic [1:0]         csr_index,
   input  wire logic [5:0]         csr_data,
   input  wire logic               req_type,
   input  wire logic [9:0]         req_client_id,
   input  wire logic [2:0]         req_work_kind,
   input  wire logic [2:0]         req_done_worker,
   input  wire logic [7:0]         req_done_tag,
   output logic [1:0]              rsp_event_res,
   output logic [2:0]              rsp_worker_sel,
   output logic [7:0]              rsp_tag_out,
   output logic [9:0]              rsp_client_out,
   output logic [2:0]              rsp_kind_out,
   output logic                    rsp_last
);
   localparam int WIW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
   localparam int WCW = $clog2(WORKERS + 1);
   localparam int TW  = $clog2(TAG_SLOTS);
   localparam int QW  = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   logic [3:0] wcount_ff;
   logic [5:0] limit_ff;
   logic [2:0] reserved_ff;

   logic [BusyW-1:0] busy_ff [WORKERS];
   logic [BusyW-1:0] proj_ff [WORKERS];
   logic [TW-1:0]    tag_ctr_ff;
   logic [EntryW-1:0] tag_mem [TAG_SLOTS];
   logic [EntryW-1:0] pq_mem [QUEUE_DEPTH];
   logic [EntryW-1:0] nq_mem [QUEUE_DEPTH];
   logic [QW-1:0]  pq_head_ff, nq_head_ff;
   logic [QCW-1:0] pq_cnt_ff, nq_cnt_ff;
   logic [QCW-1:0] pass_ff;

   logic           type_ff;
   logic [9:0]     client_ff;
   logic [2:0]     kind_ff;
   logic [2:0]     dworker_ff;
   logic [7:0]     dtag_ff;
   logic [EntryW-1:0] entry_rd_ff;
   logic [EntryW-1:0] pq_rd_ff, nq_rd_ff;

   logic [WCW-1:0] scan_ff;
   logic           hit_ff;
   logic [WIW-1:0] hit_idx_ff;

   logic [1:0] ev_ff;
   logic [2:0] wsel_ff;
   logic [7:0] tag_o_ff;
   logic [9:0] cli_o_ff;
   logic [2:0] kind_o_ff;
   logic       last_ff;

   logic [WCW-1:0] online;
   always_comb begin
      if (int'(wcount_ff) > WORKERS)
         online = WCW'(WORKERS);
      else
         online = WCW'(wcount_ff);
   end

   logic [WIW-1:0] scan_idx;
   assign scan_idx = scan_ff[WIW-1:0];

   logic [BusyW-1:0] b;
   logic [6:0]       bx, lx, l_r, l_r3, costx;
   logic             pass_ok;
   assign b     = busy_ff[scan_idx];
   assign bx    = {1'b0, b};
   assign lx    = {1'b0, limit_ff};
   assign l_r   = lx - {4'd0, reserved_ff};
   assign l_r3  = l_r - 7'd3;
   assign costx = (kind_ff == K_COMPARE) ? 7'(HeavyCost) : 7'd1;
   always_comb begin
      case (kind_ff)
         K_WISDOM:  pass_ok = (bx != l_r) && (bx <= lx);
         K_PROJECT: pass_ok = (bx <= lx) && (proj_ff[scan_idx] == '0);
         K_TELLNOW: pass_ok = bx < lx;
         K_COUNT:   pass_ok = (bx != l_r) && (bx < lx);
         K_COMPARE: pass_ok = (bx != l_r3) && (lx >= bx + 7'(HeavyCost));
         default:   pass_ok = 1'b0;
      endcase
      if (bx + costx > 7'd63) pass_ok = 1'b0;
   end

   logic is_pq;
   assign is_pq = (kind_ff == K_PROJECT) || (kind_ff == K_TELLNOW);

   logic [WIW-1:0] dw_idx;
   assign dw_idx = WIW'(dworker_ff);
   logic dw_ok;
   assign dw_ok = int'(dworker_ff) < int'(online);

   logic [2:0] e_kind;
   assign e_kind = entry_rd_ff[KindW-1:0];

   logic [BusyW-1:0] free_cost;
   assign free_cost = (e_kind == K_COMPARE) ? BusyW'(HeavyCost) : BusyW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         wcount_ff   <= 4'd1;
         limit_ff    <= 6'd24;
         reserved_ff <= 3'd1;
         for (int i = 0; i < WORKERS; i++) begin
            busy_ff[i] <= '0;
            proj_ff[i] <= '0;
         end
         tag_ctr_ff <= '0;
         pq_head_ff <= '0; nq_head_ff <= '0;
         pq_cnt_ff  <= '0; nq_cnt_ff  <= '0;
         pass_ff    <= '0;
         scan_ff    <= '0;
         hit_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_WORKERS:  wcount_ff   <= csr_data[3:0];
               CSR_LIMIT:    limit_ff    <= csr_data;
               CSR_RESERVED: reserved_ff <= csr_data[2:0];
               default: ;
            endcase
         end
         if (cmd.free && dw_ok) begin
            if (e_kind == K_PROJECT && proj_ff[dw_idx] != '0)
               proj_ff[dw_idx] <= proj_ff[dw_idx] - 1'b1;
            if (busy_ff[dw_idx] > free_cost)
               busy_ff[dw_idx] <= busy_ff[dw_idx] - free_cost;
            else
               busy_ff[dw_idx] <= '0;
         end
         if (cmd.out_done) begin
            pass_ff <= pq_cnt_ff;
         end
         if (cmd.load_nq_pass) begin
            pass_ff <= nq_cnt_ff;
         end
         if (cmd.scan_start) begin
            scan_ff <= '0;
            hit_ff  <= 1'b0;
         end
         if (cmd.scan_step && !hit_ff && scan_ff < online) begin
            if (pass_ok) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= scan_idx;
            end else begin
               scan_ff <= scan_ff + 1'b1;
            end
         end
         if (cmd.pop) begin
            pass_ff <= pass_ff - 1'b1;
            if (cmd.pop_sel_pq) begin
               pq_head_ff <= (pq_head_ff == QW'(QUEUE_DEPTH-1)) ? '0 : pq_head_ff + 1'b1;
            end else begin
               nq_head_ff <= (nq_head_ff == QW'(QUEUE_DEPTH-1)) ? '0 : nq_head_ff + 1'b1;
            end
         end
         if (cmd.commit && !sts.bad_kind) begin
            if (hit_ff) begin
               tag_ctr_ff <= tag_ctr_ff + 1'b1;
               busy_ff[hit_idx_ff] <= busy_ff[hit_idx_ff] + BusyW'(costx);
               if (kind_ff == K_PROJECT)
                  proj_ff[hit_idx_ff] <= proj_ff[hit_idx_ff] + 1'b1;
            end
         end
         // pop and push never share a cycle
         if (cmd.pop && cmd.pop_sel_pq)  pq_cnt_ff <= pq_cnt_ff - 1'b1;
         if (cmd.pop && !cmd.pop_sel_pq) nq_cnt_ff <= nq_cnt_ff - 1'b1;
         if (cmd.commit && !sts.bad_kind && !hit_ff) begin
            if (is_pq && pq_cnt_ff < QCW'(QUEUE_DEPTH)) pq_cnt_ff <= pq_cnt_ff + 1'b1;
            if (!is_pq && nq_cnt_ff < QCW'(QUEUE_DEPTH)) nq_cnt_ff <= nq_cnt_ff + 1'b1;
         end
      end
   end

   // push position = head + count mod depth
   logic [QW:0] pq_tail_sum, nq_tail_sum;
   logic [QW-1:0] pq_tail, nq_tail;
   assign pq_tail_sum = {1'b0, pq_head_ff} + (QW+1)'(pq_cnt_ff);
   assign nq_tail_sum = {1'b0, nq_head_ff} + (QW+1)'(nq_cnt_ff);
   assign pq_tail = (pq_tail_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                    QW'(pq_tail_sum - (QW+1)'(QUEUE_DEPTH)) : pq_tail_sum[QW-1:0];
   assign nq_tail = (nq_tail_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                    QW'(nq_tail_sum - (QW+1)'(QUEUE_DEPTH)) : nq_tail_sum[QW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.commit && !sts.bad_kind && hit_ff)
         tag_mem[tag_ctr_ff] <= {client_ff, kind_ff};
      if (cmd.lookup)
         entry_rd_ff <= tag_mem[TW'(dtag_ff)];
      if (cmd.commit && !sts.bad_kind && !hit_ff) begin
         if (is_pq && pq_cnt_ff < QCW'(QUEUE_DEPTH)) pq_mem[pq_tail] <= {client_ff, kind_ff};
         if (!is_pq && nq_cnt_ff < QCW'(QUEUE_DEPTH)) nq_mem[nq_tail] <= {client_ff, kind_ff};
      end
      pq_rd_ff <= pq_mem[pq_head_ff];
      nq_rd_ff <= nq_mem[nq_head_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         type_ff    <= req_type;
         client_ff  <= req_client_id;
         kind_ff    <= req_work_kind;
         dworker_ff <= req_done_worker;
         dtag_ff    <= req_done_tag;
      end
      if (cmd.pop) begin
         client_ff <= cmd.pop_sel_pq ? pq_rd_ff[EntryW-1:KindW] : nq_rd_ff[EntryW-1:KindW];
         kind_ff   <= cmd.pop_sel_pq ? pq_rd_ff[KindW-1:0] : nq_rd_ff[KindW-1:0];
      end
      if (cmd.out_done) begin
         ev_ff     <= EV_DONE;
         wsel_ff   <= dworker_ff;
         tag_o_ff  <= dtag_ff;
         cli_o_ff  <= entry_rd_ff[EntryW-1:KindW];
         kind_o_ff <= e_kind;
         last_ff   <= cmd.set_last;
      end
      if (cmd.commit) begin
         cli_o_ff  <= client_ff;
         kind_o_ff <= kind_ff;
         last_ff   <= cmd.set_last;
         if (sts.bad_kind) begin
            ev_ff <= EV_DROP; wsel_ff <= '0; tag_o_ff <= '0;
         end else if (hit_ff) begin
            ev_ff <= EV_DISPATCH; wsel_ff <= 3'(hit_idx_ff); tag_o_ff <= 8'(tag_ctr_ff);
         end else begin
            wsel_ff <= '0; tag_o_ff <= '0;
            if ((is_pq && pq_cnt_ff < QCW'(QUEUE_DEPTH)) ||
                (!is_pq && nq_cnt_ff < QCW'(QUEUE_DEPTH)))
               ev_ff <= EV_QUEUED;
            else
               ev_ff <= EV_DROP;
         end
      end
   end

   assign sts.is_done    = type_ff;
   assign sts.bad_kind   = kind_ff > K_COMPARE;
   assign sts.scan_end   = hit_ff || (scan_ff >= online);
   assign sts.pass_empty = (pass_ff == '0);
   assign sts.pq_empty   = (pq_cnt_ff == '0);
   assign sts.nq_empty   = (nq_cnt_ff == '0);

   assign rsp_event_res  = ev_ff;
   assign rsp_worker_sel = wsel_ff;
   assign rsp_tag_out    = tag_o_ff;
   assign rsp_client_out = cli_o_ff;
   assign rsp_kind_out   = kind_o_ff;
   assign rsp_last       = last_ff;

`ifndef SYNTHESIS
   a_cnt_pq: assert property (@(posedge clock) disable iff (reset)
      pq_cnt_ff <= QCW'(QUEUE_DEPTH)) else $error("priority count overflow");
   a_cnt_nq: assert property (@(posedge clock) disable iff (reset)
      nq_cnt_ff <= QCW'(QUEUE_DEPTH)) else $error("normal count overflow");
   a_tag: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !sts.bad_kind && hit_ff |=> tag_ctr_ff == $past(tag_ctr_ff) + 1'b1)
      else $error("tag not advanced");
`endif
endmodule
`default_nettype wire

// ----- sv/trd_ctrl.sv -----
// Typed request dispatcher controller: sequences lookup, scans, queue retries, output.
// Depends on trd_pkg.
`default_nettype none
module trd_ctrl
   import trd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   typedef enum logic [7:0] {
      S_IDLE   = 8'b00000001,
      S_LOOK   = 8'b00000010,
      S_FREE   = 8'b00000100,
      S_OUT    = 8'b00001000,
      S_NEXT   = 8'b00010000,
      S_POP    = 8'b00100000,
      S_SCAN   = 8'b01000000,
      S_COMMIT = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic pq_phase_ff, pq_phase_in;
   logic retry_ff, retry_in;
   logic valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      pq_phase_in = pq_phase_ff;
      retry_in = retry_ff;
      valid_in = valid_ff;
      cmd = '0;
      req_stall = 1'b1;
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.lookup = 1'b1;
            if (sts.is_done) state_in = S_FREE;
            else begin
               retry_in = 1'b0;
               cmd.scan_start = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_FREE: begin
            cmd.free = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!valid_ff || !rsp_stall) begin
               cmd.out_done = 1'b1;
               valid_in = 1'b1;
               pq_phase_in = 1'b1;
               retry_in = 1'b1;
               if (sts.pq_empty && sts.nq_empty) begin
                  cmd.set_last = 1'b1;
                  state_in = S_IDLE;
               end else state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (!sts.pass_empty) state_in = S_POP;
            else if (pq_phase_ff) begin
               pq_phase_in = 1'b0;
               cmd.load_nq_pass = 1'b1;
            end else state_in = S_IDLE;
         end
         S_POP: begin
            cmd.pop = 1'b1;
            cmd.pop_sel_pq = pq_phase_ff;
            cmd.scan_start = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_end || sts.bad_kind) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (!valid_ff || !rsp_stall) begin
               cmd.commit = 1'b1;
               valid_in = 1'b1;
               if (!retry_ff || (sts.pass_empty && (!pq_phase_ff || sts.nq_empty))) begin
                  cmd.set_last = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_NEXT;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         pq_phase_ff <= 1'b0;
         retry_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         pq_phase_ff <= pq_phase_in;
         retry_ff <= retry_in;
      end
   end

`ifndef SYNTHESIS
   a_oh: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_stall |=> valid_ff) else $error("result lost");
   a_acc: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> state_ff == S_IDLE) else $error("accept outside idle");
`endif
endmodule
`default_nettype wire

// ----- sv/typed_request_dispatcher_core.sv -----
// Typed request dispatcher top level: controller plus datapath.
// Depends on trd_pkg, trd_ctrl, trd_datapath.
//
// Usage: new requests (req_type 0) and completions (req_type 1) enter on the
// req_ channel (valid/stall). Each new request yields one result item; each
// completion yields its completion item followed by one item per queued entry
// retried (priority queue first). rsp_last marks the final result of an item.
// csr_ (valid/ready, index 0..2) is always ready; write it only between items.
// A new request's result follows acceptance through the lookup, the worker scan
// (stopping at the first worker that fits) and the commit; a completion's item
// follows the lookup, the release of its worker and the output step. Each
// retried entry passes through the pop, scan and commit steps, and moving from
// the priority to the normal queue adds a step that reloads the pass count. One item is in work
// at a time; the worker scan, one worker per cycle, sets the rate.
// Reset (synchronous) restores register defaults, empties both queues and
// clears busy counts and the tag counter. A stalled result holds rsp_ outputs
// steady, and the sequence waits at the next result until it is taken.
`default_nettype none
module typed_request_dispatcher_core
   import trd_pkg::*;
#(
   parameter int WORKERS     = 8,
   parameter int TAG_SLOTS   = 256,
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_req_type,
   input  wire logic [9:0] req_client_id,
   input  wire logic [2:0] req_work_kind,
   input  wire logic [2:0] req_done_worker,
   input  wire logic [7:0] req_done_tag,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_event_res,
   output logic [2:0]      rsp_worker_sel,
   output logic [7:0]      rsp_tag_out,
   output logic [9:0]      rsp_client_out,
   output logic [2:0]      rsp_kind_out,
   output logic            rsp_last,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [5:0] csr_data
);
   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   trd_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .sts, .cmd
   );

   trd_datapath #(.WORKERS(WORKERS), .TAG_SLOTS(TAG_SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock, .reset, .cmd, .sts,
      .csr_valid, .csr_index, .csr_data,
      .req_type(req_req_type), .req_client_id, .req_work_kind,
      .req_done_worker, .req_done_tag,
      .rsp_event_res, .rsp_worker_sel, .rsp_tag_out, .rsp_client_out,
      .rsp_kind_out, .rsp_last
   );
endmodule
`default_nettype wire

// ----- tb/dispatch_checker.sv -----
// Typed request dispatcher checker: watches the req_, rsp_ and csr_ channels,
// predicts the result rows of every accepted item and compares them in order.
// Depends on trd_pkg.
`timescale 1ns / 100ps
`default_nettype none
module dispatch_checker
   import trd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic       req_req_type,
   input  wire logic [9:0] req_client_id,
   input  wire logic [2:0] req_work_kind,
   input  wire logic [2:0] req_done_worker,
   input  wire logic [7:0] req_done_tag,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic [1:0] rsp_event_res,
   input  wire logic [2:0] rsp_worker_sel,
   input  wire logic [7:0] rsp_tag_out,
   input  wire logic [9:0] rsp_client_out,
   input  wire logic [2:0] rsp_kind_out,
   input  wire logic       rsp_last,
   input  wire logic       csr_valid,
   input  wire logic       csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [5:0] csr_data,
   output int              pending,
   output int              fail_count
);
   localparam int Workers    = 8;
   localparam int QueueDepth = 16;

   typedef struct packed {
      event_type         ev;
      logic [2:0]        worker;
      logic [7:0]        tag;
      logic [9:0]        client;
      logic [KindW-1:0]  kind;
      logic              last;
   } event_row;

   event_row          expected_events[$];
   event_row          step_rows[$];
   logic [3:0]        n_workers;
   logic [5:0]        ctx_limit;
   logic [2:0]        reserve;
   logic [BusyW-1:0]  busy[Workers];
   logic [5:0]        projects[Workers];
   logic [7:0]        issue_tag;
   logic [EntryW-1:0] tag_owner[256];
   logic [EntryW-1:0] prio_q[$];
   logic [EntryW-1:0] norm_q[$];

   assign pending = expected_events.size();

   function automatic int online();
      return (n_workers > Workers) ? Workers : int'(n_workers);
   endfunction

   function automatic bit worker_fits(int i, logic [KindW-1:0] kind);
      int b, lim, res, cost;
      b = busy[i];
      lim = ctx_limit;
      res = reserve;
      cost = (kind == K_COMPARE) ? HeavyCost : 1;
      if (b + cost > 63) return 0;
      case (kind)
         K_WISDOM:  return b != lim - res && b <= lim;
         K_PROJECT: return b <= lim && projects[i] == 0;
         K_TELLNOW: return b < lim;
         K_COUNT:   return b != lim - res && b < lim;
         K_COMPARE: return b != lim - res - 3 && lim - b >= HeavyCost;
         default:   return 0;
      endcase
   endfunction

   function automatic event_row place_entry(logic [9:0] client, logic [KindW-1:0] kind);
      event_row r;
      bit to_prio;
      r = '{ev: EV_QUEUED, worker: 0, tag: 0, client: client, kind: kind, last: 0};
      to_prio = (kind == K_PROJECT || kind == K_TELLNOW);
      for (int i = 0; i < online(); i++) begin
         if (worker_fits(i, kind)) begin
            r.ev = EV_DISPATCH;
            r.worker = i[2:0];
            r.tag = issue_tag;
            tag_owner[issue_tag] = {client, kind};
            issue_tag = issue_tag + 8'd1;
            busy[i] = BusyW'(int'(busy[i]) + ((kind == K_COMPARE) ? HeavyCost : 1));
            if (kind == K_PROJECT) projects[i] = projects[i] + 6'd1;
            return r;
         end
      end
      if (to_prio) begin
         if (prio_q.size() >= QueueDepth) r.ev = EV_DROP;
         else prio_q.insert(prio_q.size(), {client, kind});
      end else begin
         if (norm_q.size() >= QueueDepth) r.ev = EV_DROP;
         else norm_q.insert(norm_q.size(), {client, kind});
      end
      return r;
   endfunction

   task automatic predict_dispatch();
      event_row r;
      logic [EntryW-1:0] e;
      int n, cost, w;
      step_rows.delete();
      if (!req_req_type) begin
         if (req_work_kind > K_COMPARE)
            r = '{ev: EV_DROP, worker: 0, tag: 0, client: req_client_id,
                  kind: req_work_kind, last: 0};
         else
            r = place_entry(req_client_id, req_work_kind);
         step_rows.insert(step_rows.size(), r);
      end else begin
         e = tag_owner[req_done_tag];
         w = req_done_worker;
         if (w < online()) begin
            cost = (e[KindW-1:0] == K_COMPARE) ? HeavyCost : 1;
            if (e[KindW-1:0] == K_PROJECT && projects[w] > 0)
               projects[w] = projects[w] - 6'd1;
            busy[w] = (busy[w] > cost) ? BusyW'(int'(busy[w]) - cost) : '0;
         end
         r = '{ev: EV_DONE, worker: req_done_worker, tag: req_done_tag,
               client: e[EntryW-1:KindW], kind: e[KindW-1:0], last: 0};
         step_rows.insert(step_rows.size(), r);
         n = prio_q.size();
         for (int k = 0; k < n; k++) begin
            e = prio_q.pop_front();
            step_rows.insert(step_rows.size(), place_entry(e[EntryW-1:KindW], e[KindW-1:0]));
         end
         n = norm_q.size();
         for (int k = 0; k < n; k++) begin
            e = norm_q.pop_front();
            step_rows.insert(step_rows.size(), place_entry(e[EntryW-1:KindW], e[KindW-1:0]));
         end
      end
      foreach (step_rows[j]) begin
         r = step_rows[j];
         r.last = (j == step_rows.size() - 1);
         expected_events.insert(expected_events.size(), r);
      end
   endtask

   always @(posedge clock) begin
      event_row got, want;
      if (reset) begin
         n_workers <= 4'd1;
         ctx_limit <= 6'd24;
         reserve <= 3'd1;
         issue_tag = '0;
         prio_q.delete();
         norm_q.delete();
         expected_events.delete();
         fail_count <= 0;
         for (int i = 0; i < Workers; i++) begin
            busy[i] = '0;
            projects[i] = '0;
         end
         for (int i = 0; i < 256; i++) tag_owner[i] = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WORKERS:  n_workers <= csr_data[3:0];
               CSR_LIMIT:    ctx_limit <= csr_data;
               CSR_RESERVED: reserve <= csr_data[2:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{ev: event_type'(rsp_event_res), worker: rsp_worker_sel, tag: rsp_tag_out,
                    client: rsp_client_out, kind: rsp_kind_out, last: rsp_last};
            if (expected_events.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result item %p", $realtime, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_events.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) predict_dispatch();
      end
   end
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Typed request dispatcher testbench top: clock, reset, directed and random
// stimulus with idling and result stall phases, register settings and the final verdict.
// Depends on trd_pkg, typed_request_dispatcher_core and dispatch_checker.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import trd_pkg::*;

   localparam int WatchLimit = 3000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_req_type = 1'b0;
   logic [9:0] req_client_id = '0;
   logic [2:0] req_work_kind = '0;
   logic [2:0] req_done_worker = '0;
   logic [7:0] req_done_tag = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_event_res;
   logic [2:0] rsp_worker_sel;
   logic [7:0] rsp_tag_out;
   logic [9:0] rsp_client_out;
   logic [2:0] rsp_kind_out;
   logic       rsp_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [5:0] csr_data = '0;
   int         pending;
   int         fail_count;

   int         idle_pct = 0;
   int         stall_pct = 0;
   int         quiet_cycles = 0;
   logic [10:0] live_jobs[$];   // {worker, tag} of dispatched, not yet completed
   logic [7:0]  used_tags[$];
   bit          tag_seen[256];

   always #10 clock = ~clock;

   typed_request_dispatcher_core dut (.*);
   dispatch_checker checker_i (.*);

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall && rsp_event_res == EV_DISPATCH) begin
         live_jobs.insert(live_jobs.size(), {rsp_worker_sel, rsp_tag_out});
         if (!tag_seen[rsp_tag_out]) used_tags.insert(used_tags.size(), rsp_tag_out);
         tag_seen[rsp_tag_out] = 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("typed_request_dispatcher_core regression: fail");
         $finish;
      end
   end

   task automatic send_item(bit is_done, logic [9:0] client, logic [2:0] kind,
                            logic [2:0] worker, logic [7:0] tag);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_req_type <= is_done;
      req_client_id <= client;
      req_work_kind <= kind;
      req_done_worker <= worker;
      req_done_tag <= tag;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_request(logic [9:0] client, logic [2:0] kind);
      send_item(1'b0, client, kind, 3'($urandom), 8'($urandom));
   endtask

   // completes a live job, or sends a new request if none is live; noise picks any written tag and any worker
   task automatic send_completion(bit noise);
      logic [10:0] job;
      int idx;
      if (noise && used_tags.size() > 0) begin
         send_item(1'b1, 10'($urandom), 3'($urandom), 3'($urandom),
                   used_tags[$urandom_range(used_tags.size() - 1)]);
      end else if (live_jobs.size() > 0) begin
         idx = $urandom_range(live_jobs.size() - 1);
         job = live_jobs[idx];
         live_jobs.delete(idx);
         send_item(1'b1, 10'($urandom), 3'($urandom), job[10:8], job[7:0]);
      end else begin
         send_request(10'($urandom), 3'($urandom_range(4)));
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_settings(logic [5:0] workers, logic [5:0] limit, logic [5:0] rsv);
      csr_valid <= 1'b1;
      csr_index <= CSR_WORKERS;
      csr_data <= workers;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_LIMIT;
      csr_data <= limit;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_RESERVED;
      csr_data <= rsv;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [5:0] set_workers[5] = '{6'd8, 6'd1, 6'd0, 6'd15, 6'd3};
      logic [5:0] set_limit[5]   = '{6'd4, 6'd32, 6'd24, 6'd6, 6'd5};
      logic [5:0] set_rsv[5]     = '{6'd0, 6'd4, 6'd1, 6'd2, 6'd4};
      int pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every kind, field extremes, bad kinds, reserve skips
      write_settings(6'd2, 6'd4, 6'd1);
      send_request(10'd0, K_WISDOM);
      send_request(10'd1023, K_PROJECT);
      send_request(10'd1023, K_PROJECT);
      send_request(10'd5, K_TELLNOW);
      send_request(10'd682, K_COUNT);
      send_request(10'd341, K_COMPARE);
      send_request(10'd7, K_COMPARE);
      send_request(10'd9, 3'd5);
      send_request(10'd1023, 3'd6);
      send_request(10'd0, 3'd7);
      for (int i = 0; i < 5; i++) send_request(10'(i * 100), 3'(i));
      settle();
      send_completion(1'b0);
      send_completion(1'b0);
      send_item(1'b1, '0, '0, 3'd7, used_tags[0]);
      send_completion(1'b1);
      send_completion(1'b0);
      settle();

      for (int ph = 0; ph < 5; ph++) begin
         write_settings(set_workers[ph], set_limit[ph], set_rsv[ph]);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 58; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 58; end
            default: begin idle_pct = 33; stall_pct = 33; end
         endcase
         for (int n = 0; n < 38; n++) begin
            if (n == 19 && ph == 4) begin
               idle_pct = 0;
               stall_pct = 0;
            end
            pick = $urandom_range(99);
            if (set_workers[ph] == 0 && n < 30)
               send_request(10'($urandom), 3'($urandom_range(4)));
            else if (pick < 6)
               send_request(10'($urandom), 3'($urandom_range(7, 5)));
            else if (pick < 62)
               send_request(10'($urandom), 3'($urandom_range(4)));
            else
               send_completion(pick >= 94);
         end
         stall_pct = ($urandom_range(1)) ? 0 : 30;
         settle();
      end

      if (fail_count == 0 && pending == 0)
         $display("typed_request_dispatcher_core regression: pass");
      else
         $display("typed_request_dispatcher_core regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
